// ===== sv/fsip_pkg.sv =====
// Package with the shared types, character codes and conversion tables of the integer printer.
package fsip_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_CRLF = 2'd1;
    localparam logic [1:0] KIND_DEC  = 2'd2;
    localparam logic [1:0] KIND_HEX  = 2'd3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_A_LO    = 8'h61;
    localparam logic [7:0] CH_D_LO    = 8'h64;
    localparam logic [7:0] CH_X_LO    = 8'h78;

    localparam logic [3:0] DEC_TOP_POS = 4'd9;
    localparam logic [3:0] HEX_TOP_POS = 4'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic [7:0]  ch;
        logic [31:0] val;
    } cmd_t;

    function automatic logic [33:0] dec_mult(input logic [3:0] p, input logic [3:0] k);
        logic [33:0] r;
        unique case (p)
            4'd0: r = 34'(k) * 34'd1;
            4'd1: r = 34'(k) * 34'd10;
            4'd2: r = 34'(k) * 34'd100;
            4'd3: r = 34'(k) * 34'd1000;
            4'd4: r = 34'(k) * 34'd10000;
            4'd5: r = 34'(k) * 34'd100000;
            4'd6: r = 34'(k) * 34'd1000000;
            4'd7: r = 34'(k) * 34'd10000000;
            4'd8: r = 34'(k) * 34'd100000000;
            4'd9: r = 34'(k) * 34'd1000000000;
            default: r = '1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = CH_ZERO + 8'(nib);
        else
            r = CH_A_LO + 8'(nib - 4'd10);
        return r;
    endfunction

endpackage

// ===== sv/format_string_integer_printer.sv =====
// An accepted request is written into the two-entry command queue, popped by the idle
// back end into its sequencer state, and its first character is then registered into the output
// register; each skipped leading zero still takes a position step. A newline gives CR then LF,
// a negative decimal a minus sign first; requests that emit nothing never reach the queue.
// The back end takes a command only in idle, then steps one position per cycle unless stalled.
// Reset (rst_n, asynchronous, active low) clears the pending percent flag, queue and sequencer.
module format_string_integer_printer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // fmt_char [7:0], arg_value [39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char [7:0]
    output logic        m_axis_tlast    // last_of_run
);
    import fsip_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_avail;
    logic pop;
    cmd_t pop_cmd;

    fsip_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    fsip_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_avail  (pop_avail),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    fsip_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_avail     (pop_avail),
        .pop           (pop),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/fsip_front.sv =====
// Front end: accepts format requests, tracks the pending percent sign and classifies each byte.
module fsip_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,   // fmt_char [7:0], arg_value [39:8]
    output logic               push_valid,
    input  logic               push_ready,
    output fsip_pkg::cmd_t     push_cmd
);
    import fsip_pkg::*;

    logic        pend_reg;
    logic        pend_next;
    logic        accept;
    logic [7:0]  ch;
    logic [31:0] arg;

    assign ch            = s_axis_tdata[7:0];
    assign arg           = s_axis_tdata[39:8];
    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pend_next     = pend_reg;
        push_valid    = 1'b0;
        push_cmd.kind = KIND_CHAR;
        push_cmd.neg  = arg[31];
        push_cmd.ch   = ch;
        push_cmd.val  = arg;
        if (accept)
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                unique case (ch) inside
                    CH_PERCENT:
                    begin
                        push_valid = 1'b1;
                    end
                    CH_D_LO:
                    begin
                        push_valid    = 1'b1;
                        push_cmd.kind = KIND_DEC;
                        push_cmd.val  = arg[31] ? 32'd0 - arg : arg;
                    end
                    CH_X_LO, CH_X_UP:
                    begin
                        push_valid    = 1'b1;
                        push_cmd.kind = KIND_HEX;
                    end
                    default:
                    begin
                        push_valid = 1'b0;
                    end
                endcase
            end
            else if (ch == CH_PERCENT)
            begin
                pend_next = 1'b1;
            end
            else if (ch == CH_LF)
            begin
                push_valid    = 1'b1;
                push_cmd.kind = KIND_CRLF;
            end
            else if (ch != CH_NUL)
            begin
                push_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

endmodule

// ===== sv/fsip_queue.sv =====
// Short command queue between the front end and the character sequencer.
module fsip_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  fsip_pkg::cmd_t     push_cmd,
    output logic               pop_avail,
    input  logic               pop,
    output fsip_pkg::cmd_t     pop_cmd
);
    import fsip_pkg::*;

    cmd_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_avail  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_avail;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds its depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

// ===== sv/fsip_back.sv =====
// The back end turns queued commands into registered characters, at most one per cycle unless stalled.
module fsip_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_avail,
    output logic               pop,
    input  fsip_pkg::cmd_t     pop_cmd,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // out_char [7:0]
    output logic               m_axis_tlast    // last_of_run
);
    import fsip_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHAR = 3'd1;
    localparam logic [2:0] ST_CR   = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_HEX  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] val_reg, val_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        started_reg, started_next;
    logic [7:0]  char_reg, char_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_last_reg, out_last_next;

    logic        adv;
    logic        emit;
    logic        emit_last;
    logic [7:0]  emit_char;
    logic [33:0] dec_step [1:9];
    logic [9:1]  dec_ge;
    logic [3:0]  dec_digit;
    logic [33:0] dec_sub;
    logic [3:0]  nib;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign nib           = val_reg[31:28];

    for (genvar k = 1; k <= 9; k++)
    begin : g_dec
        assign dec_step[k] = dec_mult(cnt_reg, 4'(k));
        assign dec_ge[k]   = {2'b00, val_reg} >= dec_step[k];
    end

    always_comb
    begin
        dec_digit = 4'd0;
        dec_sub   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (dec_ge[k])
            begin
                dec_digit = 4'(k);
                dec_sub   = dec_step[k];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        char_next    = char_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        emit_last    = 1'b0;
        emit_char    = char_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_avail)
                begin
                    pop          = 1'b1;
                    val_next     = pop_cmd.val;
                    char_next    = pop_cmd.ch;
                    started_next = 1'b0;
                    unique case (pop_cmd.kind)
                        KIND_CHAR:
                        begin
                            state_next = ST_CHAR;
                        end
                        KIND_CRLF:
                        begin
                            state_next = ST_CR;
                        end
                        KIND_DEC:
                        begin
                            cnt_next   = DEC_TOP_POS;
                            state_next = pop_cmd.neg ? ST_SIGN : ST_DEC;
                        end
                        default:
                        begin
                            cnt_next   = HEX_TOP_POS;
                            state_next = ST_HEX;
                        end
                    endcase
                end
            end
            ST_CHAR:
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (adv)
                    state_next = ST_IDLE;
            end
            ST_CR:
            begin
                emit      = 1'b1;
                emit_char = CH_CR;
                if (adv)
                begin
                    char_next  = CH_LF;
                    state_next = ST_CHAR;
                end
            end
            ST_SIGN:
            begin
                emit      = 1'b1;
                emit_char = CH_MINUS;
                if (adv)
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                emit      = started_reg || dec_digit != 4'd0 || cnt_reg == 4'd0;
                emit_last = cnt_reg == 4'd0;
                emit_char = CH_ZERO + 8'(dec_digit);
                if (adv)
                begin
                    val_next     = val_reg - dec_sub[31:0];
                    started_next = emit;
                    cnt_next     = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                        state_next = ST_IDLE;
                end
            end
            ST_HEX:
            begin
                emit      = started_reg || nib != 4'd0 || cnt_reg == 4'd0;
                emit_last = cnt_reg == 4'd0;
                emit_char = hex_char(nib);
                if (adv)
                begin
                    val_next     = {val_reg[27:0], 4'h0};
                    started_next = emit;
                    cnt_next     = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = emit;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        char_reg     <= char_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEC |-> cnt_reg <= DEC_TOP_POS)
        else $error("decimal position out of range");

    a_hex_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HEX |-> cnt_reg <= HEX_TOP_POS)
        else $error("hex position out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("command taken while the sequencer is busy");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit && emit_last |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after the last character");

endmodule

// ===== test/format_string_integer_printer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the format string integer printer with a directed table and random runs.
module format_string_integer_printer_test;

    import fsip_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 234;
    localparam int NUM_DIRECTED = 26;

    localparam logic [127:0] HEX_GLYPHS = "0123456789abcdef";

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
    } glyph_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [31:0] arg;
        logic        typed;
        logic [3:0]  len;
        logic [87:0] golden;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // fmt_char [7:0], arg_value [39:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_char [7:0]
    logic        m_axis_tlast;   // last_of_run

    glyph_t      expected_glyphs [$];
    bit          percent_armed = 1'b0;
    bit          sender_no_idle = 1'b0;
    int          error_count = 0;
    int          requests_sent = 0;
    int          conversions_sent = 0;
    int          glyphs_checked = 0;
    int          idle_cycles = 0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h41,      32'h0000_0000, 1'b1, 4'd1,  "A"},
        '{8'hff,      32'hffff_ffff, 1'b1, 4'd1,  88'hff},
        '{CH_LF,      32'h0000_0000, 1'b1, 4'd2,  {CH_CR, CH_LF}},
        '{CH_NUL,     32'h5555_aaaa, 1'b1, 4'd0,  88'h0},
        '{CH_PERCENT, 32'h1234_5678, 1'b1, 4'd0,  88'h0},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd1,  "%"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_D_LO,    32'h0000_0000, 1'b1, 4'd1,  "0"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_X_LO,    32'h0000_0000, 1'b1, 4'd1,  "0"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_D_LO,    32'h8000_0000, 1'b1, 4'd11, "-2147483648"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_D_LO,    32'h7fff_ffff, 1'b1, 4'd10, "2147483647"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_X_LO,    32'hffff_ffff, 1'b1, 4'd8,  "ffffffff"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_X_UP,    32'h8000_0000, 1'b1, 4'd8,  "80000000"},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{8'h71,      32'hdead_beef, 1'b1, 4'd0,  88'h0},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_LF,      32'h0000_0001, 1'b1, 4'd0,  88'h0},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, 4'd0,  88'h0},
        '{CH_NUL,     32'h0000_0002, 1'b1, 4'd0,  88'h0},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, 4'd0,  88'h0},
        '{CH_D_LO,    32'd40961,     1'b0, 4'd0,  88'h0}
    };

    format_string_integer_printer DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The characters of one request, packed with the first character in the highest byte in use.
    function automatic int format_glyphs(input logic [7:0] c, input logic [31:0] arg,
                                         output logic [87:0] glyphs);
        int          n;
        int          nd;
        logic [31:0] mag;
        logic [79:0] digits;
        logic [3:0]  nib;
        bit          started;
        n = 0;
        glyphs = '0;
        if (percent_armed)
        begin
            percent_armed = 1'b0;
            if (c == CH_PERCENT)
            begin
                glyphs = {glyphs[79:0], CH_PERCENT};
                n++;
            end
            else if (c == CH_D_LO)
            begin
                mag = arg;
                if (arg[31])
                begin
                    mag = -arg;
                    glyphs = {glyphs[79:0], CH_MINUS};
                    n++;
                end
                digits = '0;
                nd = 0;
                do
                begin
                    digits = digits | (80'(CH_ZERO + 8'(mag % 32'd10)) << (nd * 8));
                    mag = mag / 32'd10;
                    nd++;
                end
                while (mag != 0);
                glyphs = (glyphs << (nd * 8)) | 88'(digits);
                n += nd;
            end
            else if (c == CH_X_LO || c == CH_X_UP)
            begin
                started = 1'b0;
                for (int s = 28; s >= 0; s -= 4)
                begin
                    nib = arg[s +: 4];
                    if (nib != 4'd0)
                        started = 1'b1;
                    if (started || s == 0)
                    begin
                        glyphs = {glyphs[79:0], HEX_GLYPHS[(15 - nib) * 8 +: 8]};
                        n++;
                    end
                end
            end
        end
        else if (c == CH_PERCENT)
        begin
            percent_armed = 1'b1;
        end
        else if (c == CH_LF)
        begin
            glyphs = {glyphs[71:0], CH_CR, CH_LF};
            n = 2;
        end
        else if (c != CH_NUL)
        begin
            glyphs = {glyphs[79:0], c};
            n = 1;
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_arg();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            5: return $urandom_range(0, 999);
            6: return -32'($urandom_range(1, 999));
            7:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7fff_ffff;
                    3: return 32'hffff_ffff;
                    default: return 32'h0000_0001;
                endcase
            end
            8: return 32'(10 ** $urandom_range(0, 9));
            9: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_conversion();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CH_D_LO;
        else if (r < 6)
            return CH_X_LO;
        else if (r == 6)
            return CH_X_UP;
        else if (r == 7)
            return CH_PERCENT;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_glyphs(input int n, input logic [87:0] glyphs);
        for (int i = 0; i < n; i++)
            expected_glyphs.push_back({glyphs[(n - 1 - i) * 8 +: 8], i == n - 1});
    endtask

    task automatic send_request(input logic [7:0] ch, input logic [31:0] arg);
        int gap;
        gap = sender_no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {arg, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic apply_request(input logic [7:0] ch, input logic [31:0] arg, input bit typed,
                                 input int len, input logic [87:0] golden);
        logic [87:0] glyphs;
        int          n;
        send_request(ch, arg);
        if (percent_armed && (ch == CH_D_LO || ch == CH_X_LO || ch == CH_X_UP))
            conversions_sent++;
        n = format_glyphs(ch, arg, glyphs);
        if (typed)
            queue_glyphs(len, golden);
        else
            queue_glyphs(n, glyphs);
        requests_sent++;
        if (requests_sent % 40 == 0)
            sender_no_idle = ($urandom_range(0, 3) == 0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_glyphs.size() != 0);
    endtask

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            glyphs_checked++;
            if (expected_glyphs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 8'h%02h", m_axis_tdata));
            end
            else
            begin
                want = expected_glyphs.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch($sformatf("out_char 8'h%02h, expected 8'h%02h",
                                              m_axis_tdata, want.ch));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b on 8'h%02h",
                                              m_axis_tlast, want.last, want.ch));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog expired with %0d characters outstanding.",
                         expected_glyphs.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(1, 8);
            if ($urandom_range(0, 7) == 0)
                hold = $urandom_range(30, 80);
            m_axis_tready <= 1'b1;
            repeat (hold) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int          r;
        logic [31:0] arg;
        bit          mid_drained;
        mid_drained   = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            apply_request(directed_rows[i].ch, directed_rows[i].arg, directed_rows[i].typed,
                          directed_rows[i].len, directed_rows[i].golden);
        wait_drained();

        while (requests_sent < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            if (!mid_drained && requests_sent >= NUM_DIRECTED + RANDOM_ITEMS / 2)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
            r = $urandom_range(0, 9);
            arg = pick_arg();
            if (r < 4)
            begin
                apply_request(CH_PERCENT, $urandom, 1'b0, 0, '0);
                apply_request(pick_conversion(), arg, 1'b0, 0, '0);
            end
            else if (r < 7)
                apply_request(8'($urandom_range(0, 255)), arg, 1'b0, 0, '0);
            else if (r == 7)
                apply_request(CH_LF, arg, 1'b0, 0, '0);
            else if (r == 8)
                apply_request(CH_PERCENT, arg, 1'b0, 0, '0);
            else
                apply_request(CH_NUL, arg, 1'b0, 0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d from the directed table, %0d integer conversions).",
                 requests_sent, NUM_DIRECTED, conversions_sent);
        $display("Checked %0d output characters, %0d mismatches.", glyphs_checked, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
